@@ hdl/aep_pkg.sv @@
// Package for the alignment error profiler: request codes, store slot
// encoding and the read-base classifier. No dependencies.
`default_nettype none

package aep_pkg;

  // Width of a reported counter value
  localparam int unsigned OUT_WIDTH = 32;

  // Character that marks a gap in either sequence
  localparam logic [7:0] GAP_CHAR = 8'd45;

  // Mismatch bases A, C, G, T, N
  localparam int unsigned NUM_BASES = 5;

  // Request types
  localparam logic REQ_COLUMN = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Read-back table selector
  localparam logic [1:0] KIND_INS = 2'd0;
  localparam logic [1:0] KIND_DEL = 2'd1;
  localparam logic [1:0] KIND_MIS = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  // Slot field of a store address: insertion, deletion, then one per base
  typedef logic [2:0] aep_slot_t;
  localparam aep_slot_t SLOT_INS  = 3'd0;
  localparam aep_slot_t SLOT_DEL  = 3'd1;
  localparam aep_slot_t SLOT_MIS0 = 3'd2;

  // Highest valid base code
  localparam logic [2:0] BASE_N = 3'd4;

  // Decoded request handed from the decoder to the update pipeline
  typedef struct packed {
    logic valid;     // request needs a store access
    logic is_read;   // read back, else counter increment
    logic query_ok;  // read back addresses a real counter
  } aep_op_t;

  // Map a read character to its base code
  function automatic logic [2:0] base_index(input logic [7:0] c);
    logic [2:0] b;
    b = BASE_N;
    unique case (c)
      8'h41, 8'h61: b = 3'd0;
      8'h43, 8'h63: b = 3'd1;
      8'h47, 8'h67: b = 3'd2;
      8'h54, 8'h74: b = 3'd3;
      default:      b = BASE_N;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/alignment_error_profiler_core.sv @@
// Alignment error profiler, top level: counter store, read-modify-write
// stage with forwarding, clearing pass. Uses aep_pkg, aep_ram,
// aep_decode and aep_out_fifo.
//
//   channel  direction  handshake                 payload
//   request  in         in_valid_i / in_stall_o   req_type_i .. query_position_i
//   result   out        out_valid_o / out_stall_i count_value_o
//
// One request per cycle while in_stall_o is low. A read request's value passes
// the store read register and the result buffer's output register; a column
// yields nothing. The counter store is one RAM, read at acceptance and written
// back in the next cycle; a back-to-back access to the same counter takes the
// word from the forwarding register. After reset a clearing pass writes zero
// to every store word, with in_stall_o high meanwhile. in_stall_o also rises
// while the result buffer and the read in flight would exceed two results.
`default_nettype none

module alignment_error_profiler_core import aep_pkg::*; #(
  parameter int unsigned MAX_POSITIONS = 256,
  parameter int unsigned NUM_BINS      = 4,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  read_char_i,
  input  wire logic [7:0]  ref_char_i,
  input  wire logic        last_column_i,
  input  wire logic        mate_i,
  input  wire logic [1:0]  mapq_bin_i,
  input  wire logic [1:0]  query_kind_i,
  input  wire logic [2:0]  query_base_i,
  input  wire logic [7:0]  query_position_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      count_value_o
);

  localparam int unsigned PW    = $clog2(MAX_POSITIONS);
  localparam int unsigned BW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned AW    = 1 + BW + 3 + PW;
  localparam int unsigned DEPTH = 2 ** AW;

  logic                   accept;
  aep_op_t                op;
  logic [AW-1:0]          op_addr;

  aep_op_t                s1_op_q;
  logic [AW-1:0]          s1_addr_q;

  logic                   fwd_valid_q;
  logic [AW-1:0]          fwd_addr_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;

  logic                   clear_busy_q;
  logic [AW-1:0]          clr_addr_q;

  logic [COUNT_WIDTH-1:0] rdata, cur, inc;
  logic                   upd_we;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;

  logic                   push;
  logic [OUT_WIDTH-1:0]   push_data;
  logic [1:0]             level;
  logic                   pop;
  logic [2:0]             occ;

  // Admit a request only if its result will find room
  assign pop        = out_valid_o && !out_stall_i;
  assign occ        = {1'b0, level} + {2'b0, s1_op_q.valid && s1_op_q.is_read};
  assign in_stall_o = clear_busy_q || (occ > (3'd1 + {2'b0, pop}));
  assign accept     = in_valid_i && !in_stall_o;

  aep_decode #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .NUM_BINS      (NUM_BINS)
  ) u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .req_type_i       (req_type_i),
    .read_char_i      (read_char_i),
    .ref_char_i       (ref_char_i),
    .last_column_i    (last_column_i),
    .mate_i           (mate_i),
    .mapq_bin_i       (mapq_bin_i),
    .query_kind_i     (query_kind_i),
    .query_base_i     (query_base_i),
    .query_position_i (query_position_i),
    .op_o             (op),
    .addr_o           (op_addr)
  );

  // Hold the request while its counter word is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_op_q <= '0;
    end else begin
      s1_op_q <= op;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= op_addr;
  end

  // Take the word written last cycle when the addresses match
  assign cur    = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rdata;
  assign inc    = (&cur) ? cur : cur + 1'b1;
  assign upd_we = s1_op_q.valid && !s1_op_q.is_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= upd_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= inc;
  end

  // Sweep the store with zeros after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_busy_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clear_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clear_busy_q <= 1'b0;
      end
    end
  end

  assign ram_we    = clear_busy_q || upd_we;
  assign ram_waddr = clear_busy_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clear_busy_q ? '0 : inc;

  aep_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (op.valid),
    .raddr_i (op_addr),
    .rdata_o (rdata)
  );

  // Saturate wide counters to the reported width; an invalid read-back yields zero
  always_comb begin
    push_data = '0;
    if (s1_op_q.query_ok) begin
      if ((COUNT_WIDTH > OUT_WIDTH) && (|(cur >> OUT_WIDTH))) begin
        push_data = '1;
      end else begin
        push_data = OUT_WIDTH'(cur);
      end
    end
  end

  assign push = s1_op_q.valid && s1_op_q.is_read;

  aep_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (count_value_o),
    .level_o     (level)
  );

endmodule

`default_nettype wire

@@ hdl/aep_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// Read returns the old word on a same-address write. No dependencies.
`default_nettype none

module aep_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, then register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/aep_decode.sv @@
// Request decoder of the alignment error profiler: column state (read
// position, gap history) and store address of each request. Uses aep_pkg.
`default_nettype none

module aep_decode import aep_pkg::*; #(
  parameter int unsigned MAX_POSITIONS = 256,
  parameter int unsigned NUM_BINS      = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic         req_type_i,
  input  wire logic [7:0]   read_char_i,
  input  wire logic [7:0]   ref_char_i,
  input  wire logic         last_column_i,
  input  wire logic         mate_i,
  input  wire logic [1:0]   mapq_bin_i,
  input  wire logic [1:0]   query_kind_i,
  input  wire logic [2:0]   query_base_i,
  input  wire logic [7:0]   query_position_i,
  output aep_op_t           op_o,
  output logic [((NUM_BINS > 1) ? $clog2(NUM_BINS) : 1) + $clog2(MAX_POSITIONS) + 3:0] addr_o
);

  localparam int unsigned PW = $clog2(MAX_POSITIONS);
  localparam int unsigned RW = $clog2(MAX_POSITIONS + 1);
  localparam int unsigned BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  logic [RW-1:0] pos_q, pos_d;
  logic          prev_read_gap_q, prev_read_gap_d;
  logic          prev_ref_gap_q, prev_ref_gap_d;
  logic          first_q, first_d;

  logic          rgap, ggap;
  logic          bin_ok, store_ok, qpos_ok, kind_ok;
  logic          upd, adv;
  aep_slot_t     col_slot, qry_slot, slot;
  logic [PW-1:0] pos_idx;
  logic [BW-1:0] bin_idx;
  logic          is_read;

  assign is_read  = (req_type_i == REQ_READ);
  assign rgap     = (read_char_i == GAP_CHAR);
  assign ggap     = (ref_char_i == GAP_CHAR);
  assign bin_ok   = (32'(mapq_bin_i) < 32'(NUM_BINS));
  assign store_ok = bin_ok && (pos_q < RW'(MAX_POSITIONS));
  assign qpos_ok  = (32'(query_position_i) < 32'(MAX_POSITIONS));
  assign bin_idx  = BW'(mapq_bin_i);

  // Classify the column: insertion, deletion, match or mismatch, double gap
  always_comb begin
    upd      = 1'b0;
    adv      = 1'b0;
    col_slot = SLOT_INS;
    if (!rgap && ggap) begin
      upd      = (first_q || !prev_ref_gap_q) && store_ok;
      adv      = 1'b1;
      col_slot = SLOT_INS;
    end else if (rgap && !ggap) begin
      upd      = (first_q || !prev_read_gap_q) && store_ok;
      col_slot = SLOT_DEL;
    end else if (!rgap && !ggap) begin
      upd      = (read_char_i != ref_char_i) && store_ok;
      adv      = 1'b1;
      col_slot = 3'(SLOT_MIS0 + base_index(read_char_i));
    end
  end

  // Select the table of a read-back request
  always_comb begin
    kind_ok  = 1'b0;
    qry_slot = SLOT_INS;
    unique case (query_kind_i)
      KIND_INS: begin
        kind_ok  = 1'b1;
        qry_slot = SLOT_INS;
      end
      KIND_DEL: begin
        kind_ok  = 1'b1;
        qry_slot = SLOT_DEL;
      end
      KIND_MIS: begin
        kind_ok  = (query_base_i <= BASE_N);
        qry_slot = 3'(SLOT_MIS0 + query_base_i);
      end
      default: begin
        kind_ok  = 1'b0;
        qry_slot = SLOT_INS;
      end
    endcase
  end

  assign slot    = is_read ? qry_slot : col_slot;
  assign pos_idx = is_read ? PW'(query_position_i) : PW'(pos_q);
  assign addr_o  = {mate_i, bin_idx, slot, pos_idx};

  assign op_o.valid    = accept_i && (is_read || upd);
  assign op_o.is_read  = is_read;
  assign op_o.query_ok = bin_ok && qpos_ok && kind_ok;

  // Advance the column state; restart it after the last column
  always_comb begin
    pos_d           = pos_q;
    prev_read_gap_d = prev_read_gap_q;
    prev_ref_gap_d  = prev_ref_gap_q;
    first_d         = first_q;
    if (accept_i && !is_read) begin
      if (last_column_i) begin
        pos_d           = '0;
        prev_read_gap_d = 1'b0;
        prev_ref_gap_d  = 1'b0;
        first_d         = 1'b1;
      end else begin
        if (adv && (pos_q < RW'(MAX_POSITIONS))) begin
          pos_d = RW'(pos_q + 1'b1);
        end
        prev_read_gap_d = rgap;
        prev_ref_gap_d  = ggap;
        first_d         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q           <= '0;
      prev_read_gap_q <= 1'b0;
      prev_ref_gap_q  <= 1'b0;
      first_q         <= 1'b1;
    end else begin
      pos_q           <= pos_d;
      prev_read_gap_q <= prev_read_gap_d;
      prev_ref_gap_q  <= prev_ref_gap_d;
      first_q         <= first_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/aep_out_fifo.sv @@
// Two-entry result buffer (output register plus skid entry) of the
// alignment error profiler. Uses aep_pkg.
`default_nettype none

module aep_out_fifo import aep_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic [OUT_WIDTH-1:0] push_data_i,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output logic [OUT_WIDTH-1:0]      out_data_o,
  output logic [1:0]                level_o
);

  logic                 head_valid_q, head_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  logic [OUT_WIDTH-1:0] head_q, head_d;
  logic [OUT_WIDTH-1:0] skid_q, skid_d;
  logic                 pop;

  assign pop = head_valid_q && !out_stall_i;

  // Refill the head from the skid entry first to keep order
  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        head_valid_d = push_i;
        head_d       = push_data_i;
      end
    end else if (push_i) begin
      if (!head_valid_q) begin
        head_valid_d = 1'b1;
        head_d       = push_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = head_valid_q;
  assign out_data_o  = head_q;
  assign level_o     = {1'b0, head_valid_q} + {1'b0, skid_valid_q};

endmodule

`default_nettype wire

@@ hdl/aep_checker.sv @@
// Port-level checker for the alignment error profiler, bound to the top
// level. Uses aep_pkg.
`default_nettype none

module aep_port_props import aep_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        req_type_i,
  input wire logic [1:0]  query_kind_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] count_value_o
);

  logic read_acc;

  assign read_acc = in_valid_i && !in_stall_o && (req_type_i == REQ_READ);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(count_value_o))
    else $error("result changed while stalled");

  // The store is being cleared right after reset
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("request taken during clearing pass");

  // A read request taken while the output is empty reaches the output
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_acc && !out_valid_o |=> ##1 out_valid_o)
    else $error("read result missing");

  // A read of the unused table returns zero once nothing is ahead of it
  a_bad_kind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_acc && !out_valid_o && !$past(read_acc) && (query_kind_i == KIND_BAD) |=> ##1
      (count_value_o == 32'd0))
    else $error("invalid read returned nonzero");

endmodule

bind alignment_error_profiler_core aep_port_props u_aep_port_props (.*);

`default_nettype wire
